// ----- sv/tpcs_pkg.sv -----
// Package for the throttled priority channel scheduler.
// Holds channel numbers, register indexes, reset values and the priority normalizer.
// No dependencies.
package tpcs_pkg;

    localparam int NUM_CH   = 4;
    localparam int CH_W     = 2;
    localparam int CHART_CH = 2;

    localparam int CH_STATE   = 0;
    localparam int CH_METRICS = 1;
    localparam int CH_SUMMARY = 3;

    localparam logic [7:0] DEFAULT_MUL = 8'd2;

    localparam logic ACT_TICK   = 1'b0;
    localparam logic ACT_REPORT = 1'b1;

    typedef enum logic [2:0] {
        CFG_STATE_ITV   = 3'd0,
        CFG_METRICS_ITV = 3'd1,
        CFG_CHART_ITV   = 3'd2,
        CFG_SUMMARY_ITV = 3'd3,
        CFG_PRIO_ORDER  = 3'd4,
        CFG_CHART_LARGE = 3'd5,
        CFG_CHART_MUL   = 3'd6,
        CFG_CLEANUP_PER = 3'd7
    } t_cfg_idx;

    localparam logic [15:0] RST_STATE_ITV   = 16'd200;
    localparam logic [15:0] RST_METRICS_ITV = 16'd1000;
    localparam logic [15:0] RST_CHART_ITV   = 16'd1000;
    localparam logic [15:0] RST_SUMMARY_ITV = 16'd2000;
    localparam logic [31:0] RST_PRIO_ORDER  = 32'h0302_0100;
    localparam logic [15:0] RST_CHART_LARGE = 16'd4096;
    localparam logic [7:0]  RST_CHART_MUL   = 8'd2;
    localparam logic [15:0] RST_CLEANUP_PER = 16'd2000;

    typedef logic [NUM_CH-1:0][CH_W-1:0] t_order;

    // Drop out-of-range and repeated bytes, then append missing channels in index order.
    function automatic t_order f_norm_order(input logic [31:0] raw);
        t_order     ord;
        logic [NUM_CH-1:0] used;
        logic [2:0] n;
        logic [7:0] b;
        ord  = '0;
        used = '0;
        n    = '0;
        for (int i = 0; i < NUM_CH; i++) begin
            b = raw[8*i +: 8];
            if (b < 8'(NUM_CH) && !used[b[CH_W-1:0]]) begin
                ord[n[CH_W-1:0]]   = b[CH_W-1:0];
                used[b[CH_W-1:0]] = 1'b1;
                n = n + 3'd1;
            end
        end
        for (int i = 0; i < NUM_CH; i++) begin
            if (!used[i] && n < 3'(NUM_CH)) begin
                ord[n[CH_W-1:0]] = CH_W'(i);
                used[i] = 1'b1;
                n = n + 3'd1;
            end
        end
        return ord;
    endfunction

endpackage

// ----- sv/throttled_priority_channel_scheduler.sv -----
// Top level of the throttled priority channel scheduler: rate-limited fixed-priority
// arbiter over four broadcast channels with a periodic cleanup pulse.
// Depends on tpcs_pkg.
//
//  channel | handshake                  | payload
//  --------+----------------------------+--------------------------------------------
//  in      | i_in_valid / o_in_stall    | i_action, i_now_ms, i_dirty_mask, i_payload_bytes
//  out     | o_out_valid / i_out_stall  | o_send_valid, o_send_channel, o_cleanup_due
//  cfg     | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
// One beat per cycle sustained while i_out_stall stays low. Each beat passes through
// the input register, then the grant logic into the output register, where its result
// waits until it is taken.
// The grant path is four parallel 32-bit wrap-around subtract/compares plus one
// 16x8 multiply for the throttled chart interval, then a four-entry priority scan.
// Reset (i_rst_n low, synchronous) loads the register defaults, clears pending
// flags and all timestamps, and empties both pipeline registers.
// o_in_stall rises only while a result waits in the output register under i_out_stall
// and a further beat already sits in the input register.
module throttled_priority_channel_scheduler
    import tpcs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // input beats
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [31:0] i_now_ms,
    input  logic [3:0]  i_dirty_mask,
    input  logic [31:0] i_payload_bytes,
    // result beats
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_send_valid,
    output logic [1:0]  o_send_channel,
    output logic        o_cleanup_due
);

    // configuration registers
    logic [NUM_CH-1:0][15:0] r_itv;
    logic [31:0]             r_prio;
    logic [15:0]             r_large;
    logic [7:0]              r_mul;
    logic [15:0]             r_cleanup_per;

    // scheduler state
    logic [NUM_CH-1:0]       r_pending,   n_pending;
    logic [NUM_CH-1:0][31:0] r_last_send, n_last_send;
    logic [31:0]             r_last_cleanup, n_last_cleanup;
    logic [31:0]             r_last_payload, n_last_payload;

    // input register
    logic        r_in_vld;
    logic        r_in_action;
    logic [31:0] r_in_now;
    logic [3:0]  r_in_dirty;
    logic [31:0] r_in_payload;

    // output register
    logic        r_out_vld;
    logic        r_send_valid;
    logic [1:0]  r_send_channel;
    logic        r_cleanup_due;

    logic                    w_adv;
    logic                    w_fire;
    logic                    w_tick;
    logic                    w_report;
    t_order                  w_order;
    logic [7:0]              w_mul_eff;
    logic [23:0]             w_chart_prod;
    logic                    w_chart_large;
    logic [NUM_CH-1:0][15:0] w_itv;
    logic [NUM_CH-1:0]       w_pend;
    logic [NUM_CH-1:0]       w_elig;
    logic                    w_grant;
    logic [CH_W-1:0]         w_grant_ch;
    logic                    w_cleanup;

    // Output register frees up when empty or being taken this cycle.
    assign w_adv      = !r_out_vld || !i_out_stall;
    assign w_fire     = r_in_vld && w_adv;
    assign o_in_stall = r_in_vld && !w_adv;
    assign w_tick     = w_fire && (r_in_action == ACT_TICK);
    assign w_report   = w_fire && (r_in_action == ACT_REPORT);

    assign w_order       = f_norm_order(r_prio);
    assign w_mul_eff     = (r_mul == 8'd0) ? DEFAULT_MUL : r_mul;
    assign w_chart_prod  = {8'd0, r_itv[CHART_CH]} * {16'd0, w_mul_eff};
    // a zero threshold makes every payload large
    assign w_chart_large = r_last_payload >= {16'd0, r_large};
    assign w_pend        = r_pending | r_in_dirty;

    // per-channel eligibility: pending and spacing reached (wrapping elapsed time)
    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            w_itv[k] = r_itv[k];
            if (k == CHART_CH && w_chart_large) begin
                w_itv[k] = w_chart_prod[15:0];
            end
            w_elig[k] = w_pend[k] && ((r_in_now - r_last_send[k]) >= {16'd0, w_itv[k]});
        end
    end

    // first eligible channel in normalized priority order
    always_comb begin
        w_grant    = 1'b0;
        w_grant_ch = '0;
        for (int i = 0; i < NUM_CH; i++) begin
            if (!w_grant && w_elig[w_order[i]]) begin
                w_grant    = 1'b1;
                w_grant_ch = w_order[i];
            end
        end
    end

    assign w_cleanup = (r_in_now - r_last_cleanup) >= {16'd0, r_cleanup_per};

    // next state
    always_comb begin
        n_pending      = r_pending;
        n_last_send    = r_last_send;
        n_last_cleanup = r_last_cleanup;
        n_last_payload = r_last_payload;
        if (w_tick) begin
            n_pending = w_pend;
            if (w_grant) begin
                n_pending[w_grant_ch]   = 1'b0;
                n_last_send[w_grant_ch] = r_in_now;
            end
            if (w_cleanup) begin
                n_last_cleanup = r_in_now;
            end
        end
        if (w_report) begin
            n_last_payload = r_in_payload;
        end
    end

    // configuration writes: the user must write only while idle; the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_itv[CH_STATE]   <= RST_STATE_ITV;
            r_itv[CH_METRICS] <= RST_METRICS_ITV;
            r_itv[CHART_CH]   <= RST_CHART_ITV;
            r_itv[CH_SUMMARY] <= RST_SUMMARY_ITV;
            r_prio            <= RST_PRIO_ORDER;
            r_large           <= RST_CHART_LARGE;
            r_mul             <= RST_CHART_MUL;
            r_cleanup_per     <= RST_CLEANUP_PER;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_STATE_ITV:   r_itv[CH_STATE]   <= i_cfg_data[15:0];
                CFG_METRICS_ITV: r_itv[CH_METRICS] <= i_cfg_data[15:0];
                CFG_CHART_ITV:   r_itv[CHART_CH]   <= i_cfg_data[15:0];
                CFG_SUMMARY_ITV: r_itv[CH_SUMMARY] <= i_cfg_data[15:0];
                CFG_PRIO_ORDER:  r_prio            <= i_cfg_data;
                CFG_CHART_LARGE: r_large           <= i_cfg_data[15:0];
                CFG_CHART_MUL:   r_mul             <= i_cfg_data[7:0];
                CFG_CLEANUP_PER: r_cleanup_per     <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // scheduler state and pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending      <= '0;
            r_last_send    <= '0;
            r_last_cleanup <= '0;
            r_last_payload <= '0;
            r_in_vld       <= 1'b0;
            r_out_vld      <= 1'b0;
        end else begin
            r_pending      <= n_pending;
            r_last_send    <= n_last_send;
            r_last_cleanup <= n_last_cleanup;
            r_last_payload <= n_last_payload;
            if (!o_in_stall) begin
                r_in_vld <= i_in_valid;
            end
            if (w_fire) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_action  <= i_action;
            r_in_now     <= i_now_ms;
            r_in_dirty   <= i_dirty_mask;
            r_in_payload <= i_payload_bytes;
        end
        if (w_fire) begin
            // a report beat returns an all-zero result
            r_send_valid   <= w_tick && w_grant;
            r_send_channel <= (w_tick && w_grant) ? w_grant_ch : '0;
            r_cleanup_due  <= w_tick && w_cleanup;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_send_valid   = r_send_valid;
    assign o_send_channel = r_send_channel;
    assign o_cleanup_due  = r_cleanup_due;

endmodule

// ----- sv/tpcs_checker.sv -----
// Port-level checker for the throttled priority channel scheduler, bound to the top level.
// Depends on tpcs_pkg and throttled_priority_channel_scheduler.
module tpcs_checker
    import tpcs_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_send_valid,
    input logic [1:0] o_send_channel
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_send_valid)
            && $stable(o_send_channel))
        else $error("result beat changed while stalled");

    // input back-pressure only when the output side is blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while output register free");

    // no grant reports channel zero
    a_no_grant_ch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_send_valid |-> o_send_channel == '0)
        else $error("channel nonzero without grant");

    // pipeline empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

endmodule

bind throttled_priority_channel_scheduler tpcs_checker u_tpcs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_send_valid   (o_send_valid),
    .o_send_channel (o_send_channel)
);

// ----- tb/sv/throttled_priority_channel_scheduler_chk.sv -----
// Scoreboard for the throttled priority channel scheduler: watches the config port and
// both beat channels, predicts each result and compares it field by field.
// Depends on tpcs_pkg.
module throttled_priority_channel_scheduler_chk
    import tpcs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_action,
    input  logic [31:0] i_now_ms,
    input  logic [3:0]  i_dirty_mask,
    input  logic [31:0] i_payload_bytes,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_send_valid,
    input  logic [1:0]  i_send_channel,
    input  logic        i_cleanup_due,
    output int          o_fail_count,
    output int          o_outstanding
);

    typedef struct packed {
        logic       send_valid;
        logic [1:0] send_channel;
        logic       cleanup_due;
    } grant_t;

    typedef logic [NUM_CH-1:0][CH_W-1:0] rank_t;

    // register shadow
    logic [15:0] spacing_ms [NUM_CH];
    logic [31:0] prio_raw;
    logic [15:0] large_bytes;
    logic [7:0]  chart_mul;
    logic [15:0] cleanup_ms;

    // arbiter state
    logic [NUM_CH-1:0] pending;
    logic [31:0]       sent_at [NUM_CH];
    logic [31:0]       cleaned_at;
    logic [31:0]       chart_bytes;

    grant_t grant_q [$];
    grant_t want;
    grant_t seen;
    int     fails = 0;

    assign o_fail_count = fails;

    function automatic void restore_defaults();
        spacing_ms[CH_STATE]   = RST_STATE_ITV;
        spacing_ms[CH_METRICS] = RST_METRICS_ITV;
        spacing_ms[CHART_CH]   = RST_CHART_ITV;
        spacing_ms[CH_SUMMARY] = RST_SUMMARY_ITV;
        prio_raw    = RST_PRIO_ORDER;
        large_bytes = RST_CHART_LARGE;
        chart_mul   = RST_CHART_MUL;
        cleanup_ms  = RST_CLEANUP_PER;
        pending     = '0;
        for (int c = 0; c < NUM_CH; c++) sent_at[c] = '0;
        cleaned_at  = '0;
        chart_bytes = '0;
    endfunction

    function automatic void apply_write(input logic [2:0] idx, input logic [31:0] data);
        case (t_cfg_idx'(idx))
            CFG_STATE_ITV:   spacing_ms[CH_STATE]   = data[15:0];
            CFG_METRICS_ITV: spacing_ms[CH_METRICS] = data[15:0];
            CFG_CHART_ITV:   spacing_ms[CHART_CH]   = data[15:0];
            CFG_SUMMARY_ITV: spacing_ms[CH_SUMMARY] = data[15:0];
            CFG_PRIO_ORDER:  prio_raw    = data;
            CFG_CHART_LARGE: large_bytes = data[15:0];
            CFG_CHART_MUL:   chart_mul   = data[7:0];
            CFG_CLEANUP_PER: cleanup_ms  = data[15:0];
            default: ;
        endcase
    endfunction

    // bad and repeated bytes drop out, missing channels fill in by index
    function automatic rank_t rank_channels();
        rank_t             rank;
        logic [NUM_CH-1:0] taken;
        logic [7:0]        b;
        int                n;
        rank  = '0;
        taken = '0;
        n     = 0;
        for (int i = 0; i < NUM_CH; i++) begin
            b = prio_raw[8*i +: 8];
            if (b < 8'(NUM_CH) && !taken[b[CH_W-1:0]]) begin
                rank[n] = b[CH_W-1:0];
                taken[b[CH_W-1:0]] = 1'b1;
                n++;
            end
        end
        for (int c = 0; c < NUM_CH; c++) begin
            if (!taken[c]) begin
                rank[n] = CH_W'(c);
                taken[c] = 1'b1;
                n++;
            end
        end
        return rank;
    endfunction

    // chart spacing is stretched while the last chart payload is large
    function automatic logic [31:0] spacing_of(input logic [CH_W-1:0] ch);
        logic [7:0]  mul;
        logic [23:0] prod;
        prod = {8'b0, spacing_ms[ch]};
        if (ch == CH_W'(CHART_CH) && chart_bytes >= {16'b0, large_bytes}) begin
            mul  = (chart_mul == 8'd0) ? DEFAULT_MUL : chart_mul;
            prod = {8'b0, spacing_ms[ch]} * {16'b0, mul};
        end
        return {16'b0, prod[15:0]};
    endfunction

    function automatic grant_t grant_for_tick(input logic [31:0] now, input logic [3:0] dirty);
        grant_t          g;
        rank_t           rank;
        logic [CH_W-1:0] ch;
        logic [31:0]     elapsed;
        g       = '0;
        rank    = rank_channels();
        pending = pending | dirty;
        for (int i = 0; i < NUM_CH; i++) begin
            ch      = rank[i];
            elapsed = now - sent_at[ch];
            if (!g.send_valid && pending[ch] && elapsed >= spacing_of(ch)) begin
                g.send_valid   = 1'b1;
                g.send_channel = ch;
                pending[ch]    = 1'b0;
                sent_at[ch]    = now;
            end
        end
        elapsed = now - cleaned_at;
        if (elapsed >= {16'b0, cleanup_ms}) begin
            g.cleanup_due = 1'b1;
            cleaned_at    = now;
        end
        return g;
    endfunction

    function automatic void check_field(input string name, input logic [1:0] exp_v,
                                        input logic [1:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restore_defaults();
            grant_q.delete();
        end else begin
            if (i_cfg_we) apply_write(i_cfg_index, i_cfg_data);
            if (i_out_valid && !i_out_stall) begin
                seen = {i_send_valid, i_send_channel, i_cleanup_due};
                if (grant_q.size() == 0) begin
                    $display("%0t: stray result beat, expected none, actual %0b/%0d/%0b",
                             $time, seen.send_valid, seen.send_channel, seen.cleanup_due);
                    fails++;
                end else begin
                    want = grant_q.pop_front();
                    check_field("send_valid", 2'(want.send_valid), 2'(seen.send_valid));
                    check_field("send_channel", want.send_channel, seen.send_channel);
                    check_field("cleanup_due", 2'(want.cleanup_due), 2'(seen.cleanup_due));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_action == ACT_REPORT) begin
                    chart_bytes = i_payload_bytes;
                    grant_q.push_back(grant_t'(0));
                end else begin
                    grant_q.push_back(grant_for_tick(i_now_ms, i_dirty_mask));
                end
            end
        end
        o_outstanding <= grant_q.size();
    end

endmodule

// ----- tb/sv/throttled_priority_channel_scheduler_tb.sv -----
// Testbench top for the throttled priority channel scheduler: drives ticks, chart size
// reports and register loads, with random idling on both channels.
// Depends on tpcs_pkg, the scheduler and throttled_priority_channel_scheduler_chk.
module throttled_priority_channel_scheduler_tb;
    import tpcs_pkg::*;

    localparam int NUM_CFG = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_action;
    logic [31:0] i_now_ms;
    logic [3:0]  i_dirty_mask;
    logic [31:0] i_payload_bytes;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_send_valid;
    logic [1:0]  o_send_channel;
    logic        o_cleanup_due;

    int fail_count;
    int outstanding;

    // next register image, indexed by t_cfg_idx
    logic [31:0] cfg_word [NUM_CFG];
    // running millisecond clock fed to ticks
    logic [31:0] t_now;
    // idle odds in percent, per beat for input gaps and per cycle for stalls; zero turns that side's idling off
    int unsigned gap_pct;
    int unsigned stall_pct;
    int          stall_left;

    throttled_priority_channel_scheduler uut (.*);

    throttled_priority_channel_scheduler_chk chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_now_ms       (i_now_ms),
        .i_dirty_mask   (i_dirty_mask),
        .i_payload_bytes(i_payload_bytes),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_send_valid   (o_send_valid),
        .i_send_channel (o_send_channel),
        .i_cleanup_due  (o_cleanup_due),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop; the slowest legal run is far shorter.
    initial begin
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Result-side backpressure: stall bursts whose length is drawn at random. A burst always runs
    // out, so stall drops once the odds go to zero.
    initial begin
        i_out_stall <= 1'b0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                if (stall_left == 0) i_out_stall <= 1'b0;
            end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
                stall_left = $urandom_range(1, 12);
                i_out_stall <= 1'b1;
            end
        end
    end

    // One input beat. An optional idle burst drops valid first; otherwise valid stays
    // high from the previous beat, so it never toggles within one step. The beat is
    // taken at the first edge where stall was low.
    task automatic put_beat(input logic act, input logic [31:0] ms, input logic [3:0] dirty,
                            input logic [31:0] bytes);
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_action        <= act;
        i_now_ms        <= ms;
        i_dirty_mask    <= dirty;
        i_payload_bytes <= bytes;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // payload field is don't-care on a tick; random so its bits still move
    task automatic tick(input logic [31:0] ms, input logic [3:0] dirty);
        put_beat(ACT_TICK, ms, dirty, $urandom());
    endtask

    // time and mask are don't-care on a report
    task automatic report(input logic [31:0] bytes);
        put_beat(ACT_REPORT, $urandom(), 4'($urandom()), bytes);
    endtask

    // Wait until every predicted beat has come back, then let the two-stage pipe
    // empty.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // Write all registers back to back on an idle block; we stays high across the burst.
    task automatic load_config();
        drain();
        for (int r = 0; r < NUM_CFG; r++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= t_cfg_idx'(r);
            i_cfg_data  <= cfg_word[r];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // interval-like value: mostly small enough for grants, sometimes zero or max,
    // now and then junk above bit 15 that the block must drop
    function automatic logic [31:0] rand_ms();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0:       v = 32'd0;
            1:       v = 32'h0000_FFFF;
            2:       v = 32'd1;
            default: v = $urandom_range(1, 3000);
        endcase
        if ($urandom_range(0, 9) == 0) v[31:16] = 16'($urandom());
        return v;
    endfunction

    task automatic rand_cfg();
        cfg_word[CFG_STATE_ITV]   = rand_ms();
        cfg_word[CFG_METRICS_ITV] = rand_ms();
        cfg_word[CFG_CHART_ITV]   = rand_ms();
        cfg_word[CFG_SUMMARY_ITV] = rand_ms();
        cfg_word[CFG_CLEANUP_PER] = rand_ms();
        case ($urandom_range(0, 2))
            0: for (int b = 0; b < NUM_CH; b++)
                   cfg_word[CFG_PRIO_ORDER][8*b +: 8] = 8'($urandom_range(0, 3));
            1: for (int b = 0; b < NUM_CH; b++)
                   cfg_word[CFG_PRIO_ORDER][8*b +: 8] = 8'($urandom_range(0, 7));
            default: cfg_word[CFG_PRIO_ORDER] = $urandom();
        endcase
        case ($urandom_range(0, 5))
            0:       cfg_word[CFG_CHART_LARGE] = 32'd0;
            1:       cfg_word[CFG_CHART_LARGE] = 32'h0000_FFFF;
            default: cfg_word[CFG_CHART_LARGE] = $urandom_range(1, 8192);
        endcase
        case ($urandom_range(0, 5))
            0:       cfg_word[CFG_CHART_MUL] = 32'd0;
            1:       cfg_word[CFG_CHART_MUL] = 32'd1;
            2:       cfg_word[CFG_CHART_MUL] = 32'd255;
            default: cfg_word[CFG_CHART_MUL] = $urandom_range(2, 8);
        endcase
        if ($urandom_range(0, 9) == 0) cfg_word[CFG_CHART_MUL][31:8] = 24'($urandom());
    endtask

    // Mostly forward-moving time with steps around the intervals so grants and
    // throttling really happen; some same-ms ticks, long jumps, random times and
    // chart size reports, some of them near the large threshold.
    task automatic run_random(input int n);
        int          pick;
        logic [31:0] bytes;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                if (pick < 4)      bytes = $urandom();
                else if (pick < 7) bytes = $urandom_range(0, 65535);
                else bytes = {16'b0, cfg_word[CFG_CHART_LARGE][15:0]} + $urandom_range(0, 2) - 1;
                report(bytes);
            end else begin
                if (pick < 14)       t_now = $urandom();
                else if (pick < 20)  t_now = t_now + $urandom_range(3000, 70000);
                else if (pick >= 65) t_now = t_now + $urandom_range(0, 3000);
                else if (pick >= 30) t_now = t_now + $urandom_range(0, 400);
                tick(t_now, ($urandom_range(0, 4) == 0) ? 4'd0 : 4'($urandom_range(1, 15)));
            end
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= CFG_STATE_ITV;
        i_cfg_data      <= '0;
        i_in_valid      <= 1'b0;
        i_action        <= ACT_TICK;
        i_now_ms        <= '0;
        i_dirty_mask    <= '0;
        i_payload_bytes <= '0;
        gap_pct   = 15;
        stall_pct = 15;
        cfg_word[CFG_STATE_ITV]   = {16'b0, RST_STATE_ITV};
        cfg_word[CFG_METRICS_ITV] = {16'b0, RST_METRICS_ITV};
        cfg_word[CFG_CHART_ITV]   = {16'b0, RST_CHART_ITV};
        cfg_word[CFG_SUMMARY_ITV] = {16'b0, RST_SUMMARY_ITV};
        cfg_word[CFG_PRIO_ORDER]  = RST_PRIO_ORDER;
        cfg_word[CFG_CHART_LARGE] = {16'b0, RST_CHART_LARGE};
        cfg_word[CFG_CHART_MUL]   = {24'b0, RST_CHART_MUL};
        cfg_word[CFG_CLEANUP_PER] = {16'b0, RST_CLEANUP_PER};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values: state 200, metrics/chart 1000, summary 2000, cleanup 2000.
        tick(32'd0, 4'h0);              // nothing pending, no cleanup at time zero
        tick(32'd100, 4'hF);            // all pending, none has waited long enough
        tick(32'd250, 4'h0);            // state first
        tick(32'd1000, 4'h0);           // metrics
        report(32'd4096);               // exactly at threshold: chart spacing doubles
        tick(32'd1500, 4'h0);           // chart held back by the doubled spacing
        tick(32'd2000, 4'h0);           // chart goes, cleanup fires
        report(32'd4095);               // just under threshold
        tick(32'hFFFF_FFF0, 4'hF);      // time near the top
        tick(32'h0000_0010, 4'h0);      // elapsed wraps across zero
        report(32'hFFFF_FFFF);

        // Zero everywhere: every pending channel always eligible, every payload large,
        // cleanup on every tick; all-ones priority bytes fall back to index order.
        cfg_word[CFG_STATE_ITV]   = 32'd0;
        cfg_word[CFG_METRICS_ITV] = 32'd0;
        cfg_word[CFG_CHART_ITV]   = 32'd0;
        cfg_word[CFG_SUMMARY_ITV] = 32'd0;
        cfg_word[CFG_PRIO_ORDER]  = 32'hFFFF_FFFF;
        cfg_word[CFG_CHART_LARGE] = 32'd0;
        cfg_word[CFG_CHART_MUL]   = 32'd0;
        cfg_word[CFG_CLEANUP_PER] = 32'd0;
        load_config();
        tick(32'h0000_0010, 4'hF);
        tick(32'h0000_0010, 4'h0);
        report(32'd0);
        tick(32'h0000_0010, 4'h0);
        tick(32'h0000_0010, 4'h8);
        tick(32'h0000_0010, 4'h0);      // nothing left pending

        // Maximum values; priority bytes: bad entry, chart, summary, repeated summary.
        cfg_word[CFG_STATE_ITV]   = 32'h0000_FFFF;
        cfg_word[CFG_METRICS_ITV] = 32'h0000_FFFF;
        cfg_word[CFG_CHART_ITV]   = 32'h0000_FFFF;
        cfg_word[CFG_SUMMARY_ITV] = 32'h0000_FFFF;
        cfg_word[CFG_PRIO_ORDER]  = 32'h0303_0207;
        cfg_word[CFG_CHART_LARGE] = 32'h0000_FFFF;
        cfg_word[CFG_CHART_MUL]   = 32'd255;
        cfg_word[CFG_CLEANUP_PER] = 32'h0000_FFFF;
        load_config();
        report(32'h0000_FFFF);          // large: chart product truncates to 16 bits
        tick(32'h0000_0020, 4'hF);
        tick(32'h0001_0010, 4'h0);
        tick(32'h0001_0010, 4'h0);
        tick(32'h8000_0000, 4'h0);
        report(32'h0000_FFFE);
        tick(32'h8000_FFFF, 4'hF);

        // Random phases, fresh settings each; the last one runs without idling.
        t_now = 32'h8001_0000;
        for (int p = 0; p < 7; p++) begin
            rand_cfg();
            load_config();
            if (p == 6) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = 10 * $urandom_range(0, 5);
                stall_pct = 10 * $urandom_range(0, 5);
            end
            if ($urandom_range(0, 3) == 0) t_now = 32'hFFFF_F000 + $urandom_range(0, 4095);
            run_random(110);
        end

        drain();
        if (fail_count == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- throttled_priority_channel_scheduler.f -----
sv/tpcs_pkg.sv
sv/throttled_priority_channel_scheduler.sv
sv/tpcs_checker.sv
tb/sv/throttled_priority_channel_scheduler_chk.sv
tb/sv/throttled_priority_channel_scheduler_tb.sv
